FILE: sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Byte classes, the job record passed from the front to the back, and the class lookup.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

    typedef enum logic [2:0] {
        CLS_CONT    = 3'd0,
        CLS_ASCII   = 3'd1,
        CLS_LEAD2   = 3'd2,
        CLS_LEAD3   = 3'd3,
        CLS_LEAD4   = 3'd4,
        CLS_INVALID = 3'd5
    } t_cls;

    localparam logic [15:0] QMARK       = 16'h003F;
    localparam logic [20:0] POINT_MAX   = 21'h10FFFF;
    localparam logic [20:0] POINT_PLANE = 21'h010000;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;

    // One decoded byte: a run of '?' for a broken sequence, then up to two tail units
    typedef struct packed {
        logic [1:0]  flush_cnt;
        logic [1:0]  tail_cnt;
        logic        tail_repl;
        logic [15:0] tail_hi;
        logic [15:0] tail_lo;
    } t_job;

    function automatic t_cls classify_lead(input logic [4:0] top5);
        t_cls cls;
        priority if (top5[4] == 1'b0) cls = CLS_ASCII;
        else if (top5[3] == 1'b0)     cls = CLS_CONT;
        else if (top5[2] == 1'b0)     cls = CLS_LEAD2;
        else if (top5[1] == 1'b0)     cls = CLS_LEAD3;
        else if (top5[0] == 1'b0)     cls = CLS_LEAD4;
        else                          cls = CLS_INVALID;
        return cls;
    endfunction

endpackage

FILE: sv/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder: one byte in, one UTF-16 unit out per cycle unless stalled.
// A byte's first unit passes through the job queue and then the output register. Reset
// clears the decoder, queue and output valid. Throughput: one byte per cycle while each
// byte yields at most one unit; the back end emits one unit per cycle, so a byte that
// yields k units holds the output while they go out and the job queue takes up the slack.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic        o_replaced,
    output logic        o_run_last
);
    import u8u16_pkg::*;

    logic w_push, w_pop, w_full, w_empty;
    t_job w_job, w_head;

    u8u16_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_job        (w_job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code_unit (o_code_unit),
        .o_replaced  (o_replaced),
        .o_run_last  (o_run_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("job popped from an empty queue");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_run_last) |=> o_valid)
        else $error("unit run broken before its last unit");

endmodule

FILE: sv/u8u16_front.sv
// Front end: accepts bytes, tracks the pending sequence and builds one job per byte.
// Depends on u8u16_pkg for the byte classes and the job record.
`timescale 1ns / 1ps

module u8u16_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_final_byte,
    input  logic                 i_full,
    output logic                 o_push,
    output u8u16_pkg::t_job      o_job
);
    import u8u16_pkg::*;

    logic [20:0] r_pp, n_pp;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [1:0]  r_bc, n_bc;

    t_cls        w_cls;
    logic [20:0] w_pp_ext;
    logic [1:0]  w_bc_inc;
    logic        w_done;
    logic [19:0] w_v;
    logic        w_accept;
    t_job        w_job;

    assign w_cls    = classify_lead(i_text_byte[7:3]);
    assign w_pp_ext = {r_pp[14:0], i_text_byte[5:0]};
    assign w_bc_inc = r_bc + 2'd1;
    assign w_done   = ({1'b0, w_bc_inc} + 3'd1) >= r_seq_len;
    assign w_v      = w_pp_ext[19:0] - POINT_PLANE[19:0];
    assign w_accept = i_valid && !i_full;

    always_comb begin
        n_pp      = r_pp;
        n_seq_len = r_seq_len;
        n_bc      = r_bc;
        w_job     = '0;
        if (r_seq_len != 3'd0 && w_cls == CLS_CONT) begin
            n_pp = w_pp_ext;
            n_bc = w_bc_inc;
            if (w_done) begin
                priority if (w_pp_ext > POINT_MAX) begin
                    w_job.tail_cnt  = 2'd1;
                    w_job.tail_hi   = QMARK;
                    w_job.tail_repl = 1'b1;
                end else if (w_pp_ext < POINT_PLANE) begin
                    w_job.tail_cnt = 2'd1;
                    w_job.tail_hi  = w_pp_ext[15:0];
                end else begin
                    w_job.tail_cnt = 2'd2;
                    w_job.tail_hi  = HI_SURR + {6'd0, w_v[19:10]};
                    w_job.tail_lo  = LO_SURR + {6'd0, w_v[9:0]};
                end
                n_pp      = '0;
                n_seq_len = 3'd0;
                n_bc      = 2'd0;
            end else if (i_final_byte) begin
                // truncated: one '?' for the lead and one per continuation
                w_job.flush_cnt = w_bc_inc + 2'd1;
                n_pp      = '0;
                n_seq_len = 3'd0;
                n_bc      = 2'd0;
            end
        end else begin
            if (r_seq_len != 3'd0) begin
                w_job.flush_cnt = r_bc + 2'd1;
                n_pp      = '0;
                n_seq_len = 3'd0;
                n_bc      = 2'd0;
            end
            unique case (w_cls)
                CLS_ASCII: begin
                    w_job.tail_cnt = 2'd1;
                    w_job.tail_hi  = {8'd0, i_text_byte};
                end
                CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                    if (i_final_byte) begin
                        w_job.tail_cnt  = 2'd1;
                        w_job.tail_hi   = QMARK;
                        w_job.tail_repl = 1'b1;
                    end else begin
                        n_seq_len = w_cls;
                        n_bc      = 2'd0;
                        unique case (w_cls)
                            CLS_LEAD2: n_pp = {16'd0, i_text_byte[4:0]};
                            CLS_LEAD3: n_pp = {17'd0, i_text_byte[3:0]};
                            default:   n_pp = {18'd0, i_text_byte[2:0]};
                        endcase
                    end
                end
                default: begin
                    w_job.tail_cnt  = 2'd1;
                    w_job.tail_hi   = QMARK;
                    w_job.tail_repl = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp      <= '0;
            r_seq_len <= 3'd0;
            r_bc      <= 2'd0;
        end else if (w_accept) begin
            r_pp      <= n_pp;
            r_seq_len <= n_seq_len;
            r_bc      <= n_bc;
        end
    end

    assign o_stall = i_full;
    // drop jobs that only extend a sequence
    assign o_push  = w_accept && (w_job.flush_cnt != 2'd0 || w_job.tail_cnt != 2'd0);
    assign o_job   = w_job;

endmodule

FILE: sv/u8u16_queue.sv
// Short job queue between the front and the back end.
// Depends on u8u16_pkg for the job record.
`timescale 1ns / 1ps

module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8u16_pkg::t_job      i_job,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output u8u16_pkg::t_job      o_head
);
    import u8u16_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wr <= wrap_inc(r_wr);
            if (i_pop)
                r_rd <= wrap_inc(r_rd);
            priority if (i_push && !i_pop)
                r_count <= r_count + CW'(1);
            else if (i_pop && !i_push)
                r_count <= r_count - CW'(1);
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

endmodule

FILE: sv/u8u16_back.sv
// Back end: expands the head job into UTF-16 units, one per cycle while not stalled.
// Output is registered. Depends on u8u16_pkg for the job record and the replacement code.
`timescale 1ns / 1ps

module u8u16_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u8u16_pkg::t_job      i_head,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_code_unit,
    output logic                 o_replaced,
    output logic                 o_run_last
);
    import u8u16_pkg::*;

    logic [1:0]  r_pos;
    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_repl;
    logic        r_last;

    logic [2:0]  w_total;
    logic        w_last;
    logic        w_load;
    logic [15:0] w_unit;
    logic        w_repl;

    assign w_total = {1'b0, i_head.flush_cnt} + {1'b0, i_head.tail_cnt};
    assign w_last  = ({1'b0, r_pos} + 3'd1) == w_total;
    assign w_load  = !i_empty && (!r_valid || !i_stall);
    assign o_pop   = w_load && w_last;

    always_comb begin
        priority if (r_pos < i_head.flush_cnt) begin
            w_unit = QMARK;
            w_repl = 1'b1;
        end else if (r_pos == i_head.flush_cnt) begin
            w_unit = i_head.tail_hi;
            w_repl = i_head.tail_repl;
        end else begin
            w_unit = i_head.tail_lo;
            w_repl = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_pos   <= w_last ? 2'd0 : r_pos + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_unit <= w_unit;
            r_repl <= w_repl;
            r_last <= w_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_code_unit = r_unit;
    assign o_replaced  = r_repl;
    assign o_run_last  = r_last;

endmodule
